// File: design/nrsp_pkg.sv
package nrsp_pkg;

    // parser phase, one code per field of a record
    typedef enum logic [2:0] {
        PH_FLAGS   = 3'd0,
        PH_TLEN    = 3'd1,
        PH_PLEN    = 3'd2,
        PH_ILEN    = 3'd3,
        PH_TYPE    = 3'd4,
        PH_ID      = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    // what one output item carries
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_TYPE    = 2'd1,
        KIND_ID      = 2'd2,
        KIND_PAYLOAD = 2'd3
    } kind_t;

    // bit positions within the record flag byte
    localparam int unsigned FL_MB_BIT = 7;
    localparam int unsigned FL_ME_BIT = 6;
    localparam int unsigned FL_CF_BIT = 5;
    localparam int unsigned FL_SR_BIT = 4;
    localparam int unsigned FL_IL_BIT = 3;

    localparam logic [7:0] MAX_RECORDS_RESET = 8'd4;
    localparam logic [7:0] RECORD_COUNT_MAX  = 8'd255;
    localparam logic [1:0] LEN_BYTES_LAST    = 2'd3;

    // choice of the next non-empty field
    typedef struct packed {
        phase_t phase;
        logic   complete;
    } pick_t;

    // one result item
    typedef struct packed {
        kind_t      byte_kind;
        logic       field_last;
        logic       ignored;
        logic       truncated;
        logic       message_done;
        logic       record_dropped;
        logic [7:0] record_index;
        logic       chunk_flag;
        logic       message_end;
        logic       message_begin;
        logic [2:0] record_tnf;
        logic [7:0] byte_value;
    } result_t;

endpackage

// File: design/ndef_record_stream_parser.sv
// ndef record stream parser: one message byte in, one tagged byte out
// output: an accepted byte's item is registered in res_reg, or in skid_reg on a stall
// throughput: one item per cycle while skid is empty; all per-byte decode sits between
//   the parser state registers and the result register; skid keeps s_tready registered
// reset: aresetn synchronous active low; clears parser state, empties result and
//   skid stages, and sets max_records to 4
module ndef_record_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: max_records
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] start_message
    input  logic        s_tlast,   // buffer_end

    // tagged byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] byte_value, [10:8] record_tnf, [11] message_begin, [12] message_end,
    // [13] chunk_flag, [21:14] record_index, [22] record_dropped,
    // [23] message_done, [24] truncated, [25] ignored, [31:26] zero
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] byte_kind
    output logic        m_tlast    // field_last
);

    // configuration register
    logic [7:0] max_records_reg;

    // parser state
    nrsp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [1:0]  len_cnt_reg, len_cnt_next;
    logic [7:0]  type_rem_reg, type_rem_next;
    logic [7:0]  id_rem_reg, id_rem_next;
    logic [31:0] pay_rem_reg, pay_rem_next;
    logic [7:0]  rec_cnt_reg, rec_cnt_next;
    logic        finished_reg, finished_next;

    // state as seen by this byte, after a message start clears it
    nrsp_pkg::phase_t phase_eff;
    logic [7:0]  flags_eff;
    logic [1:0]  len_cnt_eff;
    logic [7:0]  type_rem_eff;
    logic [7:0]  id_rem_eff;
    logic [31:0] pay_rem_eff;
    logic [7:0]  rec_cnt_eff;
    logic        finished_eff;

    // result and skid stages
    nrsp_pkg::result_t res_reg, skid_reg, res_new;
    logic              res_valid_reg, skid_valid_reg;

    logic              accept;
    logic              out_free;
    logic              start_in;
    logic              bend_in;
    logic [7:0]        byte_in;
    nrsp_pkg::kind_t   kind;
    logic              last;
    logic              complete;
    logic              me;
    nrsp_pkg::pick_t   pick;

    assign start_in = s_tuser[0];
    assign bend_in  = s_tlast;
    assign byte_in  = s_tdata;

    // skid stage full means the consumer is stalled with two items held
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !res_valid_reg || m_tready;

    // first non-empty field after the one just finished; none left ends the record
    function automatic nrsp_pkg::pick_t pick_next(
        input logic        allow_type,
        input logic        allow_id,
        input logic [7:0]  t_rem,
        input logic        il,
        input logic [7:0]  i_rem,
        input logic [31:0] p_rem
    );
        nrsp_pkg::pick_t p;
        p.complete = 1'b0;
        if (allow_type && t_rem != 8'd0) begin
            p.phase = nrsp_pkg::PH_TYPE;
        end else if (allow_id && il && i_rem != 8'd0) begin
            p.phase = nrsp_pkg::PH_ID;
        end else if (p_rem != 32'd0) begin
            p.phase = nrsp_pkg::PH_PAYLOAD;
        end else begin
            p.phase    = nrsp_pkg::PH_FLAGS;
            p.complete = 1'b1;
        end
        return p;
    endfunction

    // per-byte decode
    always_comb begin
        // a message start wipes the parser before this byte is looked at
        if (start_in) begin
            phase_eff    = nrsp_pkg::PH_FLAGS;
            flags_eff    = 8'd0;
            len_cnt_eff  = 2'd0;
            type_rem_eff = 8'd0;
            id_rem_eff   = 8'd0;
            pay_rem_eff  = 32'd0;
            rec_cnt_eff  = 8'd0;
            finished_eff = 1'b0;
        end else begin
            phase_eff    = phase_reg;
            flags_eff    = flags_reg;
            len_cnt_eff  = len_cnt_reg;
            type_rem_eff = type_rem_reg;
            id_rem_eff   = id_rem_reg;
            pay_rem_eff  = pay_rem_reg;
            rec_cnt_eff  = rec_cnt_reg;
            finished_eff = finished_reg;
        end

        phase_next    = phase_eff;
        flags_next    = flags_eff;
        len_cnt_next  = len_cnt_eff;
        type_rem_next = type_rem_eff;
        id_rem_next   = id_rem_eff;
        pay_rem_next  = pay_rem_eff;
        rec_cnt_next  = rec_cnt_eff;
        finished_next = finished_eff;

        kind     = nrsp_pkg::KIND_HEADER;
        last     = 1'b0;
        complete = 1'b0;
        pick     = '{phase: nrsp_pkg::PH_FLAGS, complete: 1'b0};

        if (!finished_eff) begin
            unique case (phase_eff)
                nrsp_pkg::PH_TLEN: begin
                    type_rem_next = byte_in;
                    len_cnt_next  = 2'd0;
                    phase_next    = nrsp_pkg::PH_PLEN;
                end
                nrsp_pkg::PH_PLEN: begin
                    // short record: one length byte, else four bytes big-endian
                    if (flags_eff[nrsp_pkg::FL_SR_BIT]) begin
                        pay_rem_next = {24'd0, byte_in};
                    end else begin
                        pay_rem_next = {pay_rem_eff[23:0], byte_in};
                    end
                    if (flags_eff[nrsp_pkg::FL_SR_BIT] ||
                        len_cnt_eff == nrsp_pkg::LEN_BYTES_LAST) begin
                        len_cnt_next = 2'd0;
                        if (flags_eff[nrsp_pkg::FL_IL_BIT]) begin
                            phase_next = nrsp_pkg::PH_ILEN;
                        end else begin
                            last       = 1'b1;
                            pick       = pick_next(1'b1, 1'b1, type_rem_eff,
                                                   flags_eff[nrsp_pkg::FL_IL_BIT],
                                                   id_rem_eff, pay_rem_next);
                            phase_next = pick.phase;
                            complete   = pick.complete;
                        end
                    end else begin
                        len_cnt_next = len_cnt_eff + 2'd1;
                    end
                end
                nrsp_pkg::PH_ILEN: begin
                    id_rem_next = byte_in;
                    last        = 1'b1;
                    pick        = pick_next(1'b1, 1'b1, type_rem_eff,
                                            flags_eff[nrsp_pkg::FL_IL_BIT],
                                            byte_in, pay_rem_eff);
                    phase_next  = pick.phase;
                    complete    = pick.complete;
                end
                nrsp_pkg::PH_TYPE: begin
                    kind = nrsp_pkg::KIND_TYPE;
                    if (type_rem_eff != 8'd0) begin
                        type_rem_next = type_rem_eff - 8'd1;
                    end
                    if (type_rem_next == 8'd0) begin
                        last       = 1'b1;
                        pick       = pick_next(1'b0, 1'b1, type_rem_next,
                                               flags_eff[nrsp_pkg::FL_IL_BIT],
                                               id_rem_eff, pay_rem_eff);
                        phase_next = pick.phase;
                        complete   = pick.complete;
                    end
                end
                nrsp_pkg::PH_ID: begin
                    kind = nrsp_pkg::KIND_ID;
                    if (id_rem_eff != 8'd0) begin
                        id_rem_next = id_rem_eff - 8'd1;
                    end
                    if (id_rem_next == 8'd0) begin
                        last       = 1'b1;
                        pick       = pick_next(1'b0, 1'b0, type_rem_eff,
                                               flags_eff[nrsp_pkg::FL_IL_BIT],
                                               id_rem_next, pay_rem_eff);
                        phase_next = pick.phase;
                        complete   = pick.complete;
                    end
                end
                nrsp_pkg::PH_PAYLOAD: begin
                    kind = nrsp_pkg::KIND_PAYLOAD;
                    if (pay_rem_eff != 32'd0) begin
                        pay_rem_next = pay_rem_eff - 32'd1;
                    end
                    // payload is the final field, so running out ends the record
                    if (pay_rem_next == 32'd0) begin
                        last       = 1'b1;
                        complete   = 1'b1;
                        phase_next = nrsp_pkg::PH_FLAGS;
                    end
                end
                default: begin
                    // flag byte, also taken for the unused phase code
                    flags_next    = byte_in;
                    len_cnt_next  = 2'd0;
                    type_rem_next = 8'd0;
                    id_rem_next   = 8'd0;
                    pay_rem_next  = 32'd0;
                    phase_next    = nrsp_pkg::PH_TLEN;
                end
            endcase
        end

        me = flags_next[nrsp_pkg::FL_ME_BIT];

        res_new.byte_value = byte_in;
        if (finished_eff) begin
            // past message end: only the byte and the ignored mark
            res_new.byte_kind      = nrsp_pkg::KIND_HEADER;
            res_new.field_last     = 1'b0;
            res_new.ignored        = 1'b1;
            res_new.truncated      = 1'b0;
            res_new.message_done   = 1'b0;
            res_new.record_dropped = 1'b0;
            res_new.record_index   = 8'd0;
            res_new.chunk_flag     = 1'b0;
            res_new.message_end    = 1'b0;
            res_new.message_begin  = 1'b0;
            res_new.record_tnf     = 3'd0;
        end else begin
            res_new.byte_kind      = kind;
            res_new.field_last     = last;
            res_new.ignored        = 1'b0;
            res_new.truncated      = bend_in && !complete;
            res_new.message_done   = complete && me;
            res_new.record_dropped = rec_cnt_eff >= max_records_reg;
            res_new.record_index   = rec_cnt_eff;
            res_new.chunk_flag     = flags_next[nrsp_pkg::FL_CF_BIT];
            res_new.message_end    = me;
            res_new.message_begin  = flags_next[nrsp_pkg::FL_MB_BIT];
            res_new.record_tnf     = flags_next[2:0];

            if (complete) begin
                if (me) begin
                    finished_next = 1'b1;
                end
                // record count saturates
                if (rec_cnt_eff != nrsp_pkg::RECORD_COUNT_MAX) begin
                    rec_cnt_next = rec_cnt_eff + 8'd1;
                end
            end
            // buffer end closes the message whether the record finished or not
            if (bend_in) begin
                finished_next = 1'b1;
            end
        end
    end

    // configuration and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_records_reg <= nrsp_pkg::MAX_RECORDS_RESET;
            phase_reg       <= nrsp_pkg::PH_FLAGS;
            flags_reg       <= 8'd0;
            len_cnt_reg     <= 2'd0;
            type_rem_reg    <= 8'd0;
            id_rem_reg      <= 8'd0;
            pay_rem_reg     <= 32'd0;
            rec_cnt_reg     <= 8'd0;
            finished_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_records_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg    <= phase_next;
                flags_reg    <= flags_next;
                len_cnt_reg  <= len_cnt_next;
                type_rem_reg <= type_rem_next;
                id_rem_reg   <= id_rem_next;
                pay_rem_reg  <= pay_rem_next;
                rec_cnt_reg  <= rec_cnt_next;
                finished_reg <= finished_next;
            end
        end
    end

    // result register with skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    res_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    res_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                res_reg <= skid_reg;
            end else if (accept) begin
                res_reg <= res_new;
            end
        end else if (accept) begin
            skid_reg <= res_new;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.byte_kind;
    assign m_tlast  = res_reg.field_last;
    assign m_tdata  = {6'd0,
                       res_reg.ignored,
                       res_reg.truncated,
                       res_reg.message_done,
                       res_reg.record_dropped,
                       res_reg.record_index,
                       res_reg.chunk_flag,
                       res_reg.message_end,
                       res_reg.message_begin,
                       res_reg.record_tnf,
                       res_reg.byte_value};

endmodule

// File: tb/sv/ndef_parse_checker.sv
module ndef_parse_checker
    import nrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          tags_pending
);

    // parser copy
    phase_t      parse_phase;
    logic [7:0]  hdr_flags;
    logic [1:0]  len_count;
    logic [7:0]  type_left;
    logic [7:0]  id_left;
    logic [31:0] payload_left;
    logic [7:0]  rec_count;
    logic        msg_over;
    logic [7:0]  rec_limit;

    result_t predicted_tags[$];
    int      fails = 0;
    int      waiting = 0;
    int      results_seen = 0;

    assign fail_count   = fails;
    assign tags_pending = waiting;

    function automatic void clear_parser();
        parse_phase  = PH_FLAGS;
        hdr_flags    = '0;
        len_count    = '0;
        type_left    = '0;
        id_left      = '0;
        payload_left = '0;
        rec_count    = '0;
        msg_over     = 1'b0;
    endfunction

    // next non-empty field after stage 0 header, 1 type, 2 id; 1 when the record is done
    function automatic logic pick_field(input int stage);
        if (stage < 1 && type_left != 0) begin
            parse_phase = PH_TYPE;
            return 1'b0;
        end
        if (stage < 2 && hdr_flags[FL_IL_BIT] && id_left != 0) begin
            parse_phase = PH_ID;
            return 1'b0;
        end
        if (payload_left != 0) begin
            parse_phase = PH_PAYLOAD;
            return 1'b0;
        end
        parse_phase = PH_FLAGS;
        return 1'b1;
    endfunction

    function automatic result_t tag_byte(input logic [7:0] b, input logic first,
                                         input logic bend);
        result_t r;
        logic    done;
        logic    me;
        r    = '0;
        done = 1'b0;
        if (first)
            clear_parser();
        r.byte_value = b;
        if (msg_over) begin
            r.ignored = 1'b1;
            return r;
        end
        r.byte_kind = KIND_HEADER;
        case (parse_phase)
            PH_TLEN: begin
                type_left   = b;
                len_count   = '0;
                parse_phase = PH_PLEN;
            end
            PH_PLEN: begin
                if (hdr_flags[FL_SR_BIT])
                    payload_left = {24'd0, b};
                else
                    payload_left = {payload_left[23:0], b};
                if (hdr_flags[FL_SR_BIT] || len_count >= LEN_BYTES_LAST) begin
                    len_count = '0;
                    if (hdr_flags[FL_IL_BIT]) begin
                        parse_phase = PH_ILEN;
                    end else begin
                        r.field_last = 1'b1;
                        done = pick_field(0);
                    end
                end else begin
                    len_count = len_count + 2'd1;
                end
            end
            PH_ILEN: begin
                id_left      = b;
                r.field_last = 1'b1;
                done = pick_field(0);
            end
            PH_TYPE: begin
                r.byte_kind = KIND_TYPE;
                if (type_left != 0)
                    type_left = type_left - 8'd1;
                if (type_left == 0) begin
                    r.field_last = 1'b1;
                    done = pick_field(1);
                end
            end
            PH_ID: begin
                r.byte_kind = KIND_ID;
                if (id_left != 0)
                    id_left = id_left - 8'd1;
                if (id_left == 0) begin
                    r.field_last = 1'b1;
                    done = pick_field(2);
                end
            end
            PH_PAYLOAD: begin
                r.byte_kind = KIND_PAYLOAD;
                if (payload_left != 0)
                    payload_left = payload_left - 32'd1;
                if (payload_left == 0) begin
                    r.field_last = 1'b1;
                    done = pick_field(3);
                end
            end
            default: begin
                // flag byte, also any unused phase code
                hdr_flags    = b;
                len_count    = '0;
                type_left    = '0;
                id_left      = '0;
                payload_left = '0;
                parse_phase  = PH_TLEN;
            end
        endcase

        me = hdr_flags[FL_ME_BIT];
        r.record_tnf     = hdr_flags[2:0];
        r.message_begin  = hdr_flags[FL_MB_BIT];
        r.message_end    = me;
        r.chunk_flag     = hdr_flags[FL_CF_BIT];
        r.record_index   = rec_count;
        r.record_dropped = (rec_count >= rec_limit);
        r.message_done   = done && me;
        r.truncated      = bend && !done;

        if (done) begin
            if (me)
                msg_over = 1'b1;
            if (rec_count < RECORD_COUNT_MAX)
                rec_count = rec_count + 8'd1;
        end
        if (bend)
            msg_over = 1'b1;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("result item %0d: %s", results_seen, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    endtask

    task automatic compare_tag(input result_t want);
        check_field("byte_kind",      m_tuser,        want.byte_kind);
        check_field("byte_value",     m_tdata[7:0],   want.byte_value);
        check_field("record_tnf",     m_tdata[10:8],  want.record_tnf);
        check_field("message_begin",  m_tdata[11],    want.message_begin);
        check_field("message_end",    m_tdata[12],    want.message_end);
        check_field("chunk_flag",     m_tdata[13],    want.chunk_flag);
        check_field("record_index",   m_tdata[21:14], want.record_index);
        check_field("record_dropped", m_tdata[22],    want.record_dropped);
        check_field("message_done",   m_tdata[23],    want.message_done);
        check_field("truncated",      m_tdata[24],    want.truncated);
        check_field("ignored",        m_tdata[25],    want.ignored);
        check_field("field_last",     m_tlast,        want.field_last);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            clear_parser();
            rec_limit = MAX_RECORDS_RESET;
            predicted_tags.delete();
        end else begin
            if (cfg_we)
                rec_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                predicted_tags.push_back(tag_byte(s_tdata, s_tuser[0], s_tlast));
            if (m_tvalid && m_tready) begin
                if (predicted_tags.size() == 0) begin
                    report("arrived with nothing predicted");
                end else begin
                    want = predicted_tags.pop_front();
                    compare_tag(want);
                end
                results_seen++;
            end
        end
        waiting = predicted_tags.size();
    end

endmodule

// File: tb/sv/tb_ndef_record_stream_parser.sv
module tb_ndef_record_stream_parser;

    import nrsp_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;  // cycles without any handshake
    localparam int LONG_HOLD       = 300;   // receiver back-pressure stretch
    localparam int CHUNK_BYTES     = 30;    // random bytes per configuration

    // one byte of an ndef message with its side flags
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       bend;
    } stream_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [0:0]  s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int tags_pending;

    // idle rates in percent, per side
    int src_gap_pct = 19;
    int snk_gap_pct = 49;

    // long hold handshake between the stimulus and the receiver process
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    int stall_cycles = 0;
    int bytes_sent   = 0;

    stream_byte_t msg_q[$];

    always #2 aclk = ~aclk;

    ndef_record_stream_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // predicts every tagged byte and compares it field by field
    ndef_parse_checker i_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .tags_pending (tags_pending)
    );

    // receiver: random stalls, or a long hold counted here when requested
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_gap_pct);
        end
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_CYCLES) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 0;
        if (r < 88)
            return $urandom_range(1, 6);
        if (r < 99)
            return $urandom_range(7, 40);
        return 255;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic first, input logic bend);
        msg_q.push_back('{data: b, first: first, bend: bend});
    endtask

    // offer one item, with an optional idle gap first; returns at the accepting edge
    task automatic send_byte(input stream_byte_t it);
        logic took;
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_gap_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tuser  <= it.first;
        s_tlast  <= it.bend;
        // s_tready is sampled away from the edge where it changes
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic flush_items();
        while (msg_q.size() != 0)
            send_byte(msg_q.pop_front());
    endtask

    // sender pauses until every predicted item has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tags_pending != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // one well-formed record with random flags and content; cut set when the
    // long length runs far past the buffer and the record must end early
    task automatic add_record(input bit first_rec, input bit last_rec, output bit cut);
        logic [7:0]  flags;
        logic [31:0] plen_word;
        int          tlen;
        int          ilen;
        int          plen;
        flags = 8'($urandom);
        flags[FL_MB_BIT] = first_rec ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        flags[FL_ME_BIT] = last_rec ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        flags[FL_SR_BIT] = ($urandom_range(3) != 0);
        tlen = pick_len();
        ilen = $urandom_range(3);
        plen = pick_len();
        plen_word = plen;
        cut = 1'b0;
        if (!flags[FL_SR_BIT] && $urandom_range(7) == 0) begin
            // huge big-endian length, only a few payload bytes before the buffer ends
            plen_word = $urandom | 32'h0100_0000;
            plen = $urandom_range(1, 5);
            cut = 1'b1;
        end
        push_item(flags, 1'b0, 1'b0);
        push_item(tlen[7:0], 1'b0, 1'b0);
        if (flags[FL_SR_BIT]) begin
            push_item(plen_word[7:0], 1'b0, 1'b0);
        end else begin
            for (int k = 3; k >= 0; k--)
                push_item(plen_word[8*k +: 8], 1'b0, 1'b0);
        end
        if (flags[FL_IL_BIT])
            push_item(ilen[7:0], 1'b0, 1'b0);
        repeat (tlen) push_item(8'($urandom), 1'b0, 1'b0);
        if (flags[FL_IL_BIT])
            repeat (ilen) push_item(8'($urandom), 1'b0, 1'b0);
        repeat (plen) push_item(8'($urandom), 1'b0, 1'b0);
    endtask

    // message of one to five records, then maybe a buffer end, a cut or trailing bytes
    task automatic build_message();
        int n_rec;
        int cut_at;
        bit cut;
        n_rec = $urandom_range(1, 5);
        cut = 1'b0;
        for (int i = 0; i < n_rec && !cut; i++)
            add_record(i == 0, i == n_rec - 1, cut);
        msg_q[0].first = 1'b1;
        if (cut) begin
            msg_q[$].bend = 1'b1;
        end else begin
            case ($urandom_range(9))
                0, 1: begin
                    // buffer ends at a random point, usually inside a record
                    cut_at = $urandom_range(msg_q.size() - 1);
                    while (msg_q.size() > cut_at + 1)
                        void'(msg_q.pop_back());
                    msg_q[$].bend = 1'b1;
                end
                2, 3, 4: msg_q[$].bend = 1'b1;
                5, 6: begin
                    // stray bytes after the message
                    repeat ($urandom_range(1, 3))
                        push_item(8'($urandom), 1'b0, $urandom_range(1) == 0);
                end
                default: ;
            endcase
        end
    endtask

    // raw bytes with random start and buffer-end marks
    task automatic build_noise();
        repeat ($urandom_range(2, 12))
            push_item(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
    endtask

    initial begin
        logic [7:0] flags;
        int         chunk_start;
        logic [7:0] limit_val;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // record with MB, short length, id present, one type and one id byte
        push_item(8'h99, 1'b1, 1'b0);
        push_item(8'h01, 1'b0, 1'b0);
        push_item(8'h02, 1'b0, 1'b0);
        push_item(8'h01, 1'b0, 1'b0);
        push_item(8'h54, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        // record with ME, CF, tnf 7, four-byte length, empty type skipped
        push_item(8'h67, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h01, 1'b0, 1'b0);
        push_item(8'hAA, 1'b0, 1'b0);
        // byte after the message end is ignored
        push_item(8'h5A, 1'b0, 1'b0);
        // new message, buffer ends inside the payload
        push_item(8'h50, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h05, 1'b0, 1'b0);
        push_item(8'hC3, 1'b0, 1'b1);
        // byte after a buffer end is ignored
        push_item(8'h3C, 1'b0, 1'b0);
        // empty record that completes exactly on the buffer end
        push_item(8'h10, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        flush_items();

        for (int chunk = 0; chunk < 6; chunk++) begin
            drain_results();
            case (chunk)
                0:       limit_val = 8'd1;
                1:       limit_val = 8'($urandom_range(2, 254));
                2:       limit_val = 8'd0;   // every record dropped
                3:       limit_val = 8'd3;
                4:       limit_val = 8'($urandom_range(1, 8));
                default: limit_val = 8'd255;
            endcase
            write_limit(limit_val);

            // receiver slow first, then sender slow, then both at full rate
            if (chunk < 2) begin
                src_gap_pct = 19;
                snk_gap_pct = 49;
            end else if (chunk < 4) begin
                src_gap_pct = 49;
                snk_gap_pct = 19;
            end else begin
                src_gap_pct = 0;
                snk_gap_pct = 0;
            end

            // long receiver hold while the sender keeps offering
            if (chunk == 1 || chunk == 3)
                hold_req <= hold_req + 1;

            if (chunk < 5) begin
                chunk_start = bytes_sent;
                while (bytes_sent - chunk_start < CHUNK_BYTES) begin
                    if ($urandom_range(19) == 0)
                        build_noise();
                    else
                        build_message();
                    flush_items();
                end
            end else begin
                // one long message of empty records drives the record count to saturation
                for (int r = 0; r < 258; r++) begin
                    flags = 8'($urandom);
                    flags[FL_MB_BIT] = (r == 0);
                    flags[FL_ME_BIT] = (r == 257);
                    flags[FL_SR_BIT] = 1'b1;
                    flags[FL_IL_BIT] = 1'b0;
                    push_item(flags, r == 0, 1'b0);
                    push_item(8'h00, 1'b0, 1'b0);
                    push_item(8'h00, 1'b0, 1'b0);
                end
                flush_items();
            end
        end

        drain_results();
        @(negedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
